// File: hdl/tst_pkg.sv
// ----------------------------------------------------------------------------
// tst_pkg: two-slot transposition table shared definitions
// Types, constants and codes used by the table top level.
// ----------------------------------------------------------------------------
package tst_pkg;

  localparam int BUCKET_COUNT = 4096;
  localparam int BKT_W        = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

  // score limits and generation tag wrap
  localparam logic signed [15:0] VAL_INF   = 16'sd32767;
  localparam logic signed [15:0] VAL_NINF  = -16'sd32767;
  localparam logic [3:0]         TAG_CYCLE = 4'd15;

  // operation codes
  localparam logic [1:0] OP_PROBE = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_ADV   = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        key_low;
    logic [31:0]        key_high;
    logic signed [7:0]  search_depth;
    logic signed [15:0] test_value;
    logic signed [15:0] eval_value;
    logic               has_move;
    logic [5:0]         move_source;
    logic [5:0]         move_target;
  } in_t;

  typedef struct packed {
    logic               entry_found;
    logic               bound_hit;
    logic signed [15:0] hit_value;
    logic [5:0]         best_source;
    logic [5:0]         best_target;
  } out_t;

  typedef struct packed {
    logic [31:0]        k2;
    logic [31:0]        k1;
    logic signed [15:0] hi2;
    logic signed [15:0] lo2;
    logic signed [15:0] hi;
    logic signed [15:0] lo;
    logic signed [7:0]  dhi2;
    logic signed [7:0]  dlo2;
    logic signed [7:0]  dhi;
    logic signed [7:0]  dlo;
    logic [5:0]         to;
    logic [5:0]         from;
    logic [3:0]         tag;
  } slot_t;

  localparam int SLOT_W   = $bits(slot_t);
  localparam int BUCKET_W = 2 * SLOT_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

// File: hdl/two_slot_transposition_table_top.sv
// ----------------------------------------------------------------------------
// two_slot_transposition_table_top: two-slot transposition table
// A command is registered on acceptance; its bucket is read, then modified and
// written in the execute state, which registers the result strobe and beat.
// A new command is taken only when idle (busy low), after the last one's execute.
// Every command returns one result beat, which the receiver cannot stall.
// Reset runs a clearing pass over every bucket of the RAM with busy high;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module two_slot_transposition_table_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  tst_pkg::in_t   in_data,
  output logic           out_valid,
  output tst_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic           cfg_wdata
);

  tst_pkg::state_t state_r, state_nxt;
  logic [tst_pkg::BKT_W-1:0] clr_r, clr_nxt;
  logic [3:0]  gen_r, gen_nxt;
  logic        cfg_r;
  tst_pkg::in_t  cmd_r;
  tst_pkg::out_t out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic        accept;
  logic        ram_we;
  logic [tst_pkg::BKT_W-1:0] ram_waddr, cmd_bkt, in_bkt;
  logic [tst_pkg::BUCKET_W-1:0] ram_wdata, ram_rdata;
  logic [tst_pkg::BUCKET_W-1:0] upd_bucket;
  logic        store_we;

  assign accept  = start && (state_r == tst_pkg::ST_IDLE);
  assign busy    = (state_r != tst_pkg::ST_IDLE);
  assign in_bkt  = in_data.key_low[tst_pkg::BKT_W:1];
  assign cmd_bkt = cmd_r.key_low[tst_pkg::BKT_W:1];

  // bucket storage
  tst_ram #(
    .WIDTH (tst_pkg::BUCKET_W),
    .DEPTH (tst_pkg::BUCKET_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_bkt),
    .rdata (ram_rdata)
  );

  assign ram_we    = (state_r == tst_pkg::ST_CLEAR) || store_we;
  assign ram_waddr = (state_r == tst_pkg::ST_CLEAR) ? clr_r : cmd_bkt;
  assign ram_wdata = (state_r == tst_pkg::ST_CLEAR) ? '0 : upd_bucket;

  // probe answer and store update of the read bucket
  always_comb begin
    tst_pkg::slot_t s0, s1, t;
    logic m0, m1, skip, drop, sel1, lower, tm;
    logic signed [7:0] d, dp0, dp1;
    s0 = ram_rdata[tst_pkg::SLOT_W-1:0];
    s1 = ram_rdata[tst_pkg::BUCKET_W-1:tst_pkg::SLOT_W];
    d  = cmd_r.search_depth;
    m0 = (s0.k1 == cmd_r.key_low) && (s0.k2 == cmd_r.key_high);
    m1 = (s1.k1 == cmd_r.key_low) && (s1.k2 == cmd_r.key_high);
    dp0 = (s0.dlo > s0.dhi) ? s0.dlo : s0.dhi;
    dp1 = (s1.dlo > s1.dhi) ? s1.dlo : s1.dhi;
    skip = cfg_r && (d[7] || (d == 8'sd0));
    drop = 1'b0;
    sel1 = 1'b0;
    out_nxt = '0;

    // probe
    t = m0 ? s0 : s1;
    if ((cmd_r.opcode == tst_pkg::OP_PROBE) && !skip && (m0 || m1)) begin
      out_nxt.entry_found = 1'b1;
      out_nxt.best_source = t.from;
      out_nxt.best_target = t.to;
      if (t.dhi >= d && t.hi < cmd_r.test_value) begin
        out_nxt.bound_hit = 1'b1;
        out_nxt.hit_value = t.hi;
      end else if (t.dlo >= d && t.lo >= cmd_r.test_value) begin
        out_nxt.bound_hit = 1'b1;
        out_nxt.hit_value = t.lo;
      end else if (t.dhi2 >= d && t.hi2 < cmd_r.test_value) begin
        out_nxt.bound_hit = 1'b1;
        out_nxt.hit_value = t.hi2;
      end else if (t.dlo2 >= d && t.lo2 >= cmd_r.test_value) begin
        out_nxt.bound_hit = 1'b1;
        out_nxt.hit_value = t.lo2;
      end
    end

    // store: slot choice
    if (m0) begin
      sel1 = 1'b0;
    end else if (m1) begin
      if (dp1 >= dp0) begin
        t  = s0;
        s0 = s1;
        s1 = t;
      end else begin
        sel1 = 1'b1;
      end
    end else if (s0.tag == gen_r && dp0 > d) begin
      drop = (d == 8'sd0) && (dp1 > 8'sd0) && (s1.tag == gen_r);
      sel1 = 1'b1;
    end else begin
      s1 = s0;
    end

    // store: bound update on the chosen slot
    t = sel1 ? s1 : s0;
    t.tag = gen_r;
    tm = (t.k1 == cmd_r.key_low) && (t.k2 == cmd_r.key_high);
    if (!tm) begin
      t.dlo = '0; t.dhi = '0; t.dlo2 = '0; t.dhi2 = '0;
      t.lo = tst_pkg::VAL_NINF; t.lo2 = tst_pkg::VAL_NINF;
      t.hi = tst_pkg::VAL_INF;  t.hi2 = tst_pkg::VAL_INF;
      t.k1 = cmd_r.key_low;
      t.k2 = cmd_r.key_high;
      t.from = '0; t.to = '0;
    end
    lower = cmd_r.eval_value >= cmd_r.test_value;
    if (lower) begin
      if (cmd_r.has_move) begin
        t.from = cmd_r.move_source;
        t.to   = cmd_r.move_target;
      end
      if (d >= t.dlo) begin
        t.dlo = d;
        t.lo  = cmd_r.eval_value;
        if (t.hi < t.lo) begin
          t.hi = tst_pkg::VAL_INF; t.dhi = '0;
        end
      end else begin
        t.dlo2 = d;
        t.lo2  = cmd_r.eval_value;
        if (t.hi2 < t.lo2) begin
          t.hi2 = tst_pkg::VAL_INF; t.dhi2 = '0;
        end
      end
    end else begin
      if (cmd_r.has_move && t.from == '0 && t.to == '0) begin
        t.from = cmd_r.move_source;
        t.to   = cmd_r.move_target;
      end
      if (d >= t.dhi) begin
        t.dhi = d;
        t.hi  = cmd_r.eval_value;
        if (t.hi < t.lo) begin
          t.lo = tst_pkg::VAL_NINF; t.dlo = '0;
        end
      end else begin
        t.dhi2 = d;
        t.hi2  = cmd_r.eval_value;
        if (t.hi2 < t.lo2) begin
          t.lo2 = tst_pkg::VAL_NINF; t.dlo2 = '0;
        end
      end
    end
    if (sel1) begin
      s1 = t;
    end else begin
      s0 = t;
    end
    upd_bucket = {s1, s0};
    store_we = (state_r == tst_pkg::ST_EXEC) && (cmd_r.opcode == tst_pkg::OP_STORE)
               && !skip && !drop;
  end

  // sequencer: clear, idle, execute
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    gen_nxt       = gen_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      tst_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = tst_pkg::ST_IDLE;
        end
      end
      tst_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = tst_pkg::ST_EXEC;
        end
      end
      tst_pkg::ST_EXEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = tst_pkg::ST_IDLE;
        if (cmd_r.opcode == tst_pkg::OP_ADV) begin
          gen_nxt = (gen_r == tst_pkg::TAG_CYCLE) ? 4'd1 : gen_r + 4'd1;
        end
      end
      default: state_nxt = tst_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tst_pkg::ST_CLEAR;
      clr_r       <= '0;
      gen_r       <= '0;
      cfg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data;
    end
    if (state_r == tst_pkg::ST_EXEC) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == tst_pkg::ST_EXEC))
    else $error("accepted command did not enter execute");

  a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == tst_pkg::ST_EXEC))
    else $error("result beat without execute cycle");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tst_pkg::ST_IDLE) |-> !ram_we)
    else $error("bucket write while idle");

  a_busy_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tst_pkg::ST_CLEAR) |-> (busy && !out_valid))
    else $error("command path active during clearing pass");

endmodule

// File: hdl/tst_ram.sv
// ----------------------------------------------------------------------------
// tst_ram: generic single-write, single-read synchronous RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
